// File: rtl/core/dro_pkg.sv
package dro_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DNUM_W  = 23;  // day number of year 16383 fits
    localparam int COUNT_W = 22;
    localparam int DATES   = 4;

    // floor(y / 100) = (y * RECIP100) >> RECIP_SHIFT, exact for y < 43690
    localparam int RECIP_SHIFT = 21;
    localparam logic [14:0] RECIP100 = 15'd20972;
    localparam int CENT_W = 8;    // floor(16383 / 100) = 163

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // load enables of the three converter stages
    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } stage_en_t;

    // month length with February taken as 28 days; 0 for a bad month
    function automatic logic [DAY_W-1:0] month_len_base(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        len = '0;
        if (m >= MONTH_JAN && m <= MONTH_DEC) begin
            if (m == MONTH_FEB)
                len = 5'd28;
            else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
                len = 5'd30;
            else
                len = 5'd31;
        end
        return len;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            4'd2:    n = 9'd31;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/core/date_range_overlap_days.sv
// Overlap length, in days, of two Gregorian date periods.
// Input channel (in_valid/in_ready): one word carries both periods, each as
// start and end dates of year, month and day. Output channel
// (out_valid/out_ready): overlap_days, the days from the later start up to
// the earlier end with the end day excluded (0 if none, saturating at the
// 22-bit maximum), and date_error, set when any of the four dates has a bad
// month or day; the count is then forced to 0.
// A word passes through five pipeline stages (three in each day-number
// converter, then min/max, then subtract/saturate), each holding one word;
// one word enters per cycle while the receiver does not stall the pipeline.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up when the receiver stalls and
// in_ready stays high until all five stages hold words and out_ready is low.
// Reset clears the valid bits only; the pipeline comes out empty.
module date_range_overlap_days
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dro_pkg::YEAR_W-1:0]   first_start_year,
    input  logic [dro_pkg::MONTH_W-1:0]  first_start_month,
    input  logic [dro_pkg::DAY_W-1:0]    first_start_day,
    input  logic [dro_pkg::YEAR_W-1:0]   first_end_year,
    input  logic [dro_pkg::MONTH_W-1:0]  first_end_month,
    input  logic [dro_pkg::DAY_W-1:0]    first_end_day,
    input  logic [dro_pkg::YEAR_W-1:0]   second_start_year,
    input  logic [dro_pkg::MONTH_W-1:0]  second_start_month,
    input  logic [dro_pkg::DAY_W-1:0]    second_start_day,
    input  logic [dro_pkg::YEAR_W-1:0]   second_end_year,
    input  logic [dro_pkg::MONTH_W-1:0]  second_end_month,
    input  logic [dro_pkg::DAY_W-1:0]    second_end_day,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dro_pkg::COUNT_W-1:0]  overlap_days,
    output logic                         date_error
);

    localparam int STAGES = 5;

    // stage valid bits; stage k loads when rdy[k]
    logic [STAGES-1:0] v_reg, v_next;
    logic [STAGES-1:0] rdy;
    logic [STAGES-1:0] v_up;

    assign v_up = {v_reg[STAGES-2:0], in_valid};

    always_comb
    begin
        rdy[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
        for (int k = 0; k < STAGES; k++)
            v_next[k] = rdy[k] ? v_up[k] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ready = rdy[0];

    dro_pkg::stage_en_t conv_en;
    assign conv_en.a = rdy[0];
    assign conv_en.b = rdy[1];
    assign conv_en.c = rdy[2];

    // date order: first start, first end, second start, second end
    logic [dro_pkg::YEAR_W-1:0]  yr  [dro_pkg::DATES];
    logic [dro_pkg::MONTH_W-1:0] mon [dro_pkg::DATES];
    logic [dro_pkg::DAY_W-1:0]   dy  [dro_pkg::DATES];
    logic [dro_pkg::DNUM_W-1:0]  dnum[dro_pkg::DATES];
    logic [dro_pkg::DATES-1:0]   dok;

    assign yr[0]  = first_start_year;
    assign mon[0] = first_start_month;
    assign dy[0]  = first_start_day;
    assign yr[1]  = first_end_year;
    assign mon[1] = first_end_month;
    assign dy[1]  = first_end_day;
    assign yr[2]  = second_start_year;
    assign mon[2] = second_start_month;
    assign dy[2]  = second_start_day;
    assign yr[3]  = second_end_year;
    assign mon[3] = second_end_month;
    assign dy[3]  = second_end_day;

    for (genvar i = 0; i < dro_pkg::DATES; i++)
    begin : g_conv
        dro_date_conv u_conv
        (
            .clk     (clk),
            .en      (conv_en),
            .year    (yr[i]),
            .month   (mon[i]),
            .day     (dy[i]),
            .day_num (dnum[i]),
            .date_ok (dok[i])
        );
    end

    // stage D: later start, earlier end
    logic [dro_pkg::DNUM_W-1:0] start_d_reg, start_d_next;
    logic [dro_pkg::DNUM_W-1:0] end_d_reg, end_d_next;
    logic                       err_d_reg;

    assign start_d_next = (dnum[0] > dnum[2]) ? dnum[0] : dnum[2];
    assign end_d_next   = (dnum[1] < dnum[3]) ? dnum[1] : dnum[3];

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            start_d_reg <= start_d_next;
            end_d_reg   <= end_d_next;
            err_d_reg   <= !(&dok);
        end
    end

    // stage E: difference, saturate, error override; output register
    logic [dro_pkg::DNUM_W-1:0]  diff;
    logic [dro_pkg::COUNT_W-1:0] count_e_reg, count_e_next;
    logic                        err_e_reg;

    assign diff = end_d_reg - start_d_reg;

    always_comb
    begin
        if (err_d_reg || !(start_d_reg < end_d_reg))
            count_e_next = '0;
        else if (diff[dro_pkg::DNUM_W-1])
            count_e_next = '1;
        else
            count_e_next = diff[dro_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            count_e_reg <= count_e_next;
            err_e_reg   <= err_d_reg;
        end
    end

    assign out_valid    = v_reg[STAGES-1];
    assign overlap_days = count_e_reg;
    assign date_error   = err_e_reg;

`ifndef NO_ASSERTIONS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && date_error |-> overlap_days == '0)
        else $error("count not zero on date error");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted word missing from first stage");

    a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> in_ready)
        else $error("input stalled with empty first stage");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&v_reg) && !out_ready |-> !in_ready)
        else $error("input accepted into full stalled pipeline");
`endif

endmodule

// File: rtl/core/dro_date_conv.sv
// Three-stage date to day-number converter with date check.
module dro_date_conv
(
    input  logic                               clk,
    input  dro_pkg::stage_en_t                 en,
    input  logic [dro_pkg::YEAR_W-1:0]         year,
    input  logic [dro_pkg::MONTH_W-1:0]        month,
    input  logic [dro_pkg::DAY_W-1:0]          day,
    output logic [dro_pkg::DNUM_W-1:0]         day_num,
    output logic                               date_ok
);

    // stage A: century quotient, base day check
    logic [dro_pkg::YEAR_W-1:0]  year_a_reg;
    logic [dro_pkg::MONTH_W-1:0] month_a_reg;
    logic [dro_pkg::DAY_W-1:0]   day_a_reg;
    logic [dro_pkg::CENT_W-1:0]  cent_a_reg, cent_a_next;
    logic                        ok_base_a_reg, ok_base_a_next;
    logic                        feb29_a_reg, feb29_a_next;
    logic [28:0]                 prod_a;

    assign prod_a       = 29'(year) * 29'(dro_pkg::RECIP100);
    assign cent_a_next  = prod_a[dro_pkg::RECIP_SHIFT +: dro_pkg::CENT_W];
    assign ok_base_a_next = (day != '0) && (day <= dro_pkg::month_len_base(month));
    assign feb29_a_next = (month == dro_pkg::MONTH_FEB) && (day == 5'd29);

    always_ff @(posedge clk)
    begin
        if (en.a)
        begin
            year_a_reg    <= year;
            month_a_reg   <= month;
            day_a_reg     <= day;
            cent_a_reg    <= cent_a_next;
            ok_base_a_reg <= ok_base_a_next;
            feb29_a_reg   <= feb29_a_next;
        end
    end

    // stage B: leap year, rounded-up quotients, partial sums
    logic [6:0]                  rem100;
    logic                        leap;
    logic [dro_pkg::CENT_W-1:0]  c100;
    logic [dro_pkg::DNUM_W-1:0]  y365_b_reg, y365_b_next;
    logic [12:0]                 quad_b_reg, quad_b_next;
    logic [dro_pkg::CENT_W-1:0]  c100_b_reg;
    logic [5:0]                  c400_b_reg, c400_b_next;
    logic [8:0]                  tail_b_reg, tail_b_next;
    logic                        ok_b_reg, ok_b_next;
    logic [14:0]                 cent_x100;
    logic [14:0]                 year_p3;
    logic [8:0]                  c100_p3;

    assign cent_x100 = 15'(cent_a_reg) * 15'd100;
    assign rem100    = 7'(15'(year_a_reg) - cent_x100);
    assign leap      = (year_a_reg[1:0] == 2'd0) && ((rem100 != '0) || (cent_a_reg[1:0] == 2'd0));
    assign c100      = cent_a_reg + dro_pkg::CENT_W'(rem100 != '0);
    assign c100_p3   = 9'(c100) + 9'd3;
    assign c400_b_next = c100_p3[7:2];
    assign year_p3   = 15'(year_a_reg) + 15'd3;
    assign quad_b_next = year_p3[14:2];
    assign y365_b_next = dro_pkg::DNUM_W'(year_a_reg) * dro_pkg::DNUM_W'(365);
    assign tail_b_next = dro_pkg::days_before_month(month_a_reg)
                       + 9'((month_a_reg > dro_pkg::MONTH_FEB) && leap)
                       + 9'(day_a_reg);
    assign ok_b_next = ok_base_a_reg || (feb29_a_reg && leap);

    always_ff @(posedge clk)
    begin
        if (en.b)
        begin
            y365_b_reg <= y365_b_next;
            quad_b_reg <= quad_b_next;
            c100_b_reg <= c100;
            c400_b_reg <= c400_b_next;
            tail_b_reg <= tail_b_next;
            ok_b_reg   <= ok_b_next;
        end
    end

    // stage C: final day number
    logic [dro_pkg::DNUM_W:0]   sum_c;
    logic [dro_pkg::DNUM_W-1:0] num_c_reg;
    logic                       ok_c_reg;

    assign sum_c = 24'(y365_b_reg) + 24'(quad_b_reg) - 24'(c100_b_reg)
                 + 24'(c400_b_reg) + 24'(tail_b_reg);

    always_ff @(posedge clk)
    begin
        if (en.c)
        begin
            num_c_reg <= sum_c[dro_pkg::DNUM_W-1:0];
            ok_c_reg  <= ok_b_reg;
        end
    end

    assign day_num = num_c_reg;
    assign date_ok = ok_c_reg;

endmodule

// File: bench/tb.sv
module tb;

    localparam int unsigned HALF_PERIOD = 4;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned PIPE_LATENCY = 5;
    localparam int unsigned RANDOM_WORDS = 2000;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam longint unsigned COUNT_MAX = (64'd1 << dro_pkg::COUNT_W) - 1;

    typedef struct packed {
        logic [dro_pkg::YEAR_W-1:0]  year;
        logic [dro_pkg::MONTH_W-1:0] month;
        logic [dro_pkg::DAY_W-1:0]   day;
    } date_t;

    // one word: both periods
    typedef struct packed {
        date_t fs;  // first start
        date_t fe;  // first end
        date_t ss;  // second start
        date_t se;  // second end
    } periods_t;

    typedef struct packed {
        logic     hold_for_drain;  // wait until every owed result has come back
        periods_t q;
    } feed_word_t;

    typedef struct packed {
        logic [dro_pkg::COUNT_W-1:0] days;
        logic                        err;
    } overlap_t;

    // ------------------------------------------------------------------
    // clock, reset, DUT ports
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [dro_pkg::YEAR_W-1:0]   first_start_year = '0;
    logic [dro_pkg::MONTH_W-1:0]  first_start_month = '0;
    logic [dro_pkg::DAY_W-1:0]    first_start_day = '0;
    logic [dro_pkg::YEAR_W-1:0]   first_end_year = '0;
    logic [dro_pkg::MONTH_W-1:0]  first_end_month = '0;
    logic [dro_pkg::DAY_W-1:0]    first_end_day = '0;
    logic [dro_pkg::YEAR_W-1:0]   second_start_year = '0;
    logic [dro_pkg::MONTH_W-1:0]  second_start_month = '0;
    logic [dro_pkg::DAY_W-1:0]    second_start_day = '0;
    logic [dro_pkg::YEAR_W-1:0]   second_end_year = '0;
    logic [dro_pkg::MONTH_W-1:0]  second_end_month = '0;
    logic [dro_pkg::DAY_W-1:0]    second_end_day = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [dro_pkg::COUNT_W-1:0]  overlap_days;
    logic                         date_error;

    always #(HALF_PERIOD) clk = ~clk;

    date_range_overlap_days u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .first_start_year   (first_start_year),
        .first_start_month  (first_start_month),
        .first_start_day    (first_start_day),
        .first_end_year     (first_end_year),
        .first_end_month    (first_end_month),
        .first_end_day      (first_end_day),
        .second_start_year  (second_start_year),
        .second_start_month (second_start_month),
        .second_start_day   (second_start_day),
        .second_end_year    (second_end_year),
        .second_end_month   (second_end_month),
        .second_end_day     (second_end_day),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .overlap_days       (overlap_days),
        .date_error         (date_error)
    );

    // ------------------------------------------------------------------
    // calendar predictor
    // ------------------------------------------------------------------
    function automatic logic is_leap(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // 0 for a month outside 1..12
    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        case (m)
            2:                        return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:              return 30;
            1, 3, 5, 7, 8, 10, 12:    return 31;
            default:                  return 0;
        endcase
    endfunction

    // cumulative days before each month, non-leap year
    function automatic int unsigned cum_days(int unsigned m);
        case (m)
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            12:      return 334;
            default: return 0;
        endcase
    endfunction

    function automatic logic date_valid(date_t dt);
        return (dt.day != '0) &&
               (32'(dt.day) <= days_in_month(32'(dt.year), 32'(dt.month)));
    endfunction

    // serial day count from 1 Jan of year 0, proleptic Gregorian
    function automatic longint unsigned day_serial(date_t dt);
        longint unsigned y;
        longint unsigned n;
        y = 64'(dt.year);
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        n += 64'(cum_days(32'(dt.month)));
        if (dt.month > 2 && is_leap(32'(dt.year)))
            n += 1;
        return n + 64'(dt.day);
    endfunction

    function automatic overlap_t predict_overlap(periods_t p);
        overlap_t r;
        longint unsigned a0, a1, b0, b1, lo, hi, span;
        r.days = '0;
        r.err = 1'b0;
        if (!date_valid(p.fs) || !date_valid(p.fe) || !date_valid(p.ss) || !date_valid(p.se))
        begin
            r.err = 1'b1;
            return r;
        end
        a0 = day_serial(p.fs);
        a1 = day_serial(p.fe);
        b0 = day_serial(p.ss);
        b1 = day_serial(p.se);
        lo = (a0 > b0) ? a0 : b0;
        hi = (a1 < b1) ? a1 : b1;
        if (lo < hi)
        begin
            span = hi - lo;
            if (span > COUNT_MAX)
                span = COUNT_MAX;
            r.days = span[dro_pkg::COUNT_W-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic date_t mk_date(int unsigned y, int unsigned m, int unsigned d);
        date_t dt;
        dt.year = y[dro_pkg::YEAR_W-1:0];
        dt.month = m[dro_pkg::MONTH_W-1:0];
        dt.day = d[dro_pkg::DAY_W-1:0];
        return dt;
    endfunction

    function automatic periods_t mk_periods(date_t a, date_t b, date_t c, date_t d);
        periods_t p;
        p.fs = a;
        p.fe = b;
        p.ss = c;
        p.se = d;
        return p;
    endfunction

    function automatic date_t rand_valid_date(int unsigned ylo, int unsigned yhi);
        int unsigned y, m;
        y = $urandom_range(yhi, ylo);
        m = $urandom_range(12, 1);
        return mk_date(y, m, $urandom_range(days_in_month(y, m), 1));
    endfunction

    function automatic date_t rand_raw_date();
        return mk_date($urandom_range(16383, 0), $urandom_range(15, 0), $urandom_range(31, 0));
    endfunction

    function automatic periods_t rand_periods();
        periods_t p;
        int unsigned kind, base, spread, pick;
        date_t bad;
        kind = $urandom_range(99, 0);
        if (kind < 58)
        begin
            // clustered dates so the periods really overlap
            base = $urandom_range(9996, 1);
            pick = $urandom_range(2, 0);
            spread = (pick == 0) ? 0 : (pick == 1) ? 1 : 3;
            p = mk_periods(rand_valid_date(base, base + spread),
                           rand_valid_date(base, base + spread),
                           rand_valid_date(base, base + spread),
                           rand_valid_date(base, base + spread));
        end
        else if (kind < 68)
        begin
            // anywhere in the 14-bit year range
            p = mk_periods(rand_valid_date(0, 16383), rand_valid_date(0, 16383),
                           rand_valid_date(0, 16383), rand_valid_date(0, 16383));
        end
        else if (kind < 76)
        begin
            // very long periods, some of them past the count ceiling
            p = mk_periods(rand_valid_date(0, 3000), rand_valid_date(11000, 16383),
                           rand_valid_date(0, 3000), rand_valid_date(11000, 16383));
        end
        else if (kind < 90)
        begin
            // one date with raw month/day, which may be bad
            base = $urandom_range(9996, 1);
            p = mk_periods(rand_valid_date(base, base + 2), rand_valid_date(base, base + 2),
                           rand_valid_date(base, base + 2), rand_valid_date(base, base + 2));
            bad = mk_date(base + $urandom_range(2, 0), $urandom_range(15, 0),
                          $urandom_range(31, 0));
            case ($urandom_range(3, 0))
                0:       p.fs = bad;
                1:       p.fe = bad;
                2:       p.ss = bad;
                default: p.se = bad;
            endcase
        end
        else
        begin
            p = mk_periods(rand_raw_date(), rand_raw_date(), rand_raw_date(), rand_raw_date());
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of words with random gaps
    // ------------------------------------------------------------------
    feed_word_t  feed_q[$];
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    int unsigned words_sent = 0;
    int unsigned drain_waits = 0;
    int unsigned results_owed = 0;  // monitor-owned, updated nonblocking

    always @(posedge clk)
    begin : driver
        logic       launch;
        feed_word_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            // slot is free: either idle or the held word went in at this edge
            launch = 1'b0;
            if (gap_left != 0)
                gap_left--;
            else if (feed_q.size() != 0)
            begin
                // a drain word waits for an idle input and no results owed;
                // results_owed already counts anything accepted up to last edge
                if (!feed_q[0].hold_for_drain || (!in_valid && results_owed == 0))
                    launch = 1'b1;
            end

            if (launch)
            begin
                nxt = feed_q.pop_front();
                if (nxt.hold_for_drain)
                    drain_waits++;
                first_start_year   <= nxt.q.fs.year;
                first_start_month  <= nxt.q.fs.month;
                first_start_day    <= nxt.q.fs.day;
                first_end_year     <= nxt.q.fe.year;
                first_end_month    <= nxt.q.fe.month;
                first_end_day      <= nxt.q.fe.day;
                second_start_year  <= nxt.q.ss.year;
                second_start_month <= nxt.q.ss.month;
                second_start_day   <= nxt.q.ss.day;
                second_end_year    <= nxt.q.se.year;
                second_end_month   <= nxt.q.se.month;
                second_end_day     <= nxt.q.se.day;
                in_valid <= 1'b1;
                words_sent++;
                if (burst_left != 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    // new burst; some bursts are long and back to back
                    if ($urandom_range(9, 0) == 0)
                    begin
                        burst_left = $urandom_range(200, 80);
                        gap_left = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(40, 1);
                        gap_left = ($urandom_range(9, 0) < 4) ? 0 : $urandom_range(12, 1);
                    end
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts at input accept, checks at output accept,
    // and drives out_ready on its own stall pattern
    // ------------------------------------------------------------------
    overlap_t    owed_q[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned n_flagged = 0;
    int unsigned n_zero = 0;
    int unsigned n_capped = 0;
    int unsigned ready_mode = 0;
    int unsigned ready_span = 0;

    always @(posedge clk)
    begin : monitor
        overlap_t got;
        overlap_t want;
        periods_t seen;
        logic     rdy;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            results_owed <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.days = overlap_days;
                got.err = date_error;
                results_seen++;
                if (owed_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("MISMATCH: result days=%0d err=%0b with none owed",
                                 got.days, got.err);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (got.days !== want.days || got.err !== want.err)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"MISMATCH: result %0d expected days=%0d err=%0b,",
                                      " got days=%0d err=%0b"},
                                     results_seen, want.days, want.err, got.days, got.err);
                    end
                end
                if (got.err === 1'b1)
                    n_flagged++;
                else if (got.days == '0)
                    n_zero++;
                else if (got.days == COUNT_MAX[dro_pkg::COUNT_W-1:0])
                    n_capped++;
            end

            if (in_valid && in_ready)
            begin
                seen.fs = {first_start_year, first_start_month, first_start_day};
                seen.fe = {first_end_year, first_end_month, first_end_day};
                seen.ss = {second_start_year, second_start_month, second_start_day};
                seen.se = {second_end_year, second_end_month, second_end_day};
                owed_q.push_back(predict_overlap(seen));
            end
            results_owed <= owed_q.size();

            // receiver pattern: free-running, coin flip, regular on/off toggling, hard stall
            if (ready_span == 0)
            begin
                ready_mode = $urandom_range(3, 0);
                ready_span = (ready_mode == 3) ? $urandom_range(25, 1) : $urandom_range(60, 10);
            end
            ready_span--;
            case (ready_mode)
                0:       rdy = 1'b1;
                1:       rdy = 1'($urandom_range(1, 0));
                2:       rdy = ready_span[1];
                default: rdy = 1'b0;
            endcase
            out_ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, results_owed);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        feed_word_t fw;
        int unsigned k;

        fw.hold_for_drain = 1'b0;
        // plain overlap inside one leap year: Feb 1 .. Mar 5 2020
        fw.q = mk_periods(mk_date(2020, 1, 10), mk_date(2020, 3, 5),
                          mk_date(2020, 2, 1), mk_date(2020, 4, 1));
        feed_q.push_back(fw);
        // identical one-day periods
        fw.q = mk_periods(mk_date(2021, 6, 1), mk_date(2021, 6, 2),
                          mk_date(2021, 6, 1), mk_date(2021, 6, 2));
        feed_q.push_back(fw);
        // periods touching at one day: end excluded, so no overlap
        fw.q = mk_periods(mk_date(2021, 1, 1), mk_date(2021, 2, 1),
                          mk_date(2021, 2, 1), mk_date(2021, 3, 1));
        feed_q.push_back(fw);
        // disjoint, second before first
        fw.q = mk_periods(mk_date(2022, 5, 1), mk_date(2022, 6, 1),
                          mk_date(2019, 1, 1), mk_date(2019, 12, 31));
        feed_q.push_back(fw);
        // reversed first period: not an error, no overlap
        fw.q = mk_periods(mk_date(2023, 9, 30), mk_date(2023, 1, 1),
                          mk_date(2023, 1, 1), mk_date(2023, 12, 31));
        feed_q.push_back(fw);
        // Feb 29 on a 400-year leap year, across the month boundary
        fw.q = mk_periods(mk_date(2000, 2, 29), mk_date(2000, 3, 2),
                          mk_date(2000, 2, 1), mk_date(2000, 12, 31));
        feed_q.push_back(fw);
        // Feb 29 on a 100-year non-leap year
        fw.q = mk_periods(mk_date(1900, 1, 1), mk_date(1900, 3, 1),
                          mk_date(1900, 2, 29), mk_date(1900, 4, 1));
        feed_q.push_back(fw);
        // Feb 29 on a 4-year leap year is fine, Feb 30 is not
        fw.q = mk_periods(mk_date(2024, 2, 29), mk_date(2024, 3, 1),
                          mk_date(2024, 2, 1), mk_date(2024, 3, 1));
        feed_q.push_back(fw);
        fw.q = mk_periods(mk_date(2024, 2, 1), mk_date(2024, 2, 30),
                          mk_date(2024, 2, 1), mk_date(2024, 3, 1));
        feed_q.push_back(fw);
        // bad month 0, 13, 15 and bad day 0, Apr 31, one per word
        fw.q = mk_periods(mk_date(2010, 0, 5), mk_date(2010, 6, 1),
                          mk_date(2010, 1, 1), mk_date(2010, 6, 1));
        feed_q.push_back(fw);
        fw.q = mk_periods(mk_date(2010, 1, 5), mk_date(2010, 6, 1),
                          mk_date(2010, 1, 1), mk_date(2010, 13, 1));
        feed_q.push_back(fw);
        fw.q = mk_periods(mk_date(2010, 1, 5), mk_date(2010, 15, 1),
                          mk_date(2010, 1, 1), mk_date(2010, 6, 1));
        feed_q.push_back(fw);
        fw.q = mk_periods(mk_date(2010, 1, 5), mk_date(2010, 6, 1),
                          mk_date(2010, 1, 0), mk_date(2010, 6, 1));
        feed_q.push_back(fw);
        fw.q = mk_periods(mk_date(2010, 1, 5), mk_date(2010, 4, 31),
                          mk_date(2010, 1, 1), mk_date(2010, 6, 1));
        feed_q.push_back(fw);
        // range-edge years: year 0 is leap, year 16383 at its last day
        fw.q = mk_periods(mk_date(0, 2, 29), mk_date(16383, 12, 31),
                          mk_date(0, 1, 1), mk_date(1, 1, 1));
        feed_q.push_back(fw);
        // widest periods: count saturates
        fw.q = mk_periods(mk_date(0, 1, 1), mk_date(16383, 12, 31),
                          mk_date(0, 1, 1), mk_date(16383, 12, 31));
        feed_q.push_back(fw);
        // year 1 .. 9999: large count below the ceiling
        fw.q = mk_periods(mk_date(1, 1, 1), mk_date(9999, 12, 31),
                          mk_date(1, 1, 1), mk_date(9999, 12, 31));
        feed_q.push_back(fw);
        // year rollover, one day
        fw.q = mk_periods(mk_date(1999, 12, 31), mk_date(2000, 1, 1),
                          mk_date(1999, 1, 1), mk_date(2001, 1, 1));
        feed_q.push_back(fw);
        // every field all ones, then all zeros
        fw.q = mk_periods(mk_date(16383, 15, 31), mk_date(16383, 15, 31),
                          mk_date(16383, 15, 31), mk_date(16383, 15, 31));
        feed_q.push_back(fw);
        fw.q = '0;
        feed_q.push_back(fw);

        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            // drain before the random part, twice inside it, and now and then
            fw.hold_for_drain = (k == 0) || (k == 700) || (k == 1400) ||
                                ($urandom_range(199, 0) == 0);
            fw.q = rand_periods();
            feed_q.push_back(fw);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sample on the falling edge, clear of the rising-edge updates
        do @(negedge clk); while (feed_q.size() != 0 || in_valid);
        do @(negedge clk); while (results_owed != 0);
        repeat (PIPE_LATENCY * 4) @(negedge clk);

        if (owed_q.size() != 0)
        begin
            mismatches += owed_q.size();
            $display("MISMATCH: %0d results never arrived", owed_q.size());
        end

        $display("Ran %0d date-period words (%0d after a full drain) in %0d cycles.",
                 words_sent, drain_waits, cycle_count);
        $display("Results: %0d checked, %0d bad-date, %0d no-overlap, %0d capped, %0d mismatches.",
                 results_seen, n_flagged, n_zero, n_capped, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: date_range_overlap_days.f
rtl/core/dro_pkg.sv
rtl/core/dro_date_conv.sv
rtl/core/date_range_overlap_days.sv
bench/tb.sv
